@@ src/generational_handle_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle allocator
// Concurrent checks that compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GHA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GHA_NEVER(lbl, clk, rst, expr, msg) \
   `GHA_ASSERT(lbl, clk, rst, !(expr), msg)
`else
`define GHA_ASSERT(lbl, clk, rst, prop, msg)
`define GHA_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

@@ src/gha_pkg.sv @@
// ----------------------------------------------------------------------------
// gha_pkg
// Types, codes and sizes shared by the handle allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gha_pkg;
   localparam int SLOTS       = 256;
   localparam int QUEUE_DEPTH = 256;
   localparam int SLOT_BITS   = 8;
   localparam int UNIQUE_BITS = 32;
   localparam int CNT_BITS    = 9;
   localparam int QIDX_BITS   = 8;

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_CHECK  = 3'd1;
   localparam logic [2:0] OP_QUEUE  = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_FLUSH  = 3'd4;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NOT_ALIVE    = 3'd1;
   localparam logic [2:0] ST_UNALLOCATED  = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL   = 3'd3;
   localparam logic [2:0] ST_IDS_EXHAUST  = 3'd4;
   localparam logic [2:0] ST_QUEUE_FULL   = 3'd5;

   localparam logic CSR_FIRST_UID = 1'b0;
   localparam logic CSR_UID_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      K_CREATE, K_CHECK, K_QUEUE, K_REMOVE, K_FLUSH, K_NOP
   } kind_type;

   typedef struct packed {
      logic [2:0]             op;
      logic [SLOT_BITS-1:0]   slot_index;
      logic [UNIQUE_BITS-1:0] handle_unique;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic                   is_alive;
      logic [SLOT_BITS-1:0]   new_slot;
      logic [UNIQUE_BITS-1:0] new_unique;
      logic [CNT_BITS-1:0]    live_count;
      logic [31:0]            created_total;
      logic [31:0]            removed_total;
      logic [CNT_BITS-1:0]    flushed_count;
   } rsp_type;

   typedef struct packed {
      kind_type               kind;
      logic [SLOT_BITS-1:0]   slot;
      logic [UNIQUE_BITS-1:0] uniq;
   } cmd_type;
endpackage
`default_nettype wire

@@ src/gha_ram.sv @@
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

@@ src/gha_front.sv @@
// ----------------------------------------------------------------------------
// gha_front
// Accepts requests, decodes the op and buffers two commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gha_front import gha_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd_data,
   input  wire logic    cmd_take
);
   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       push;

   always_comb begin
      dec.slot = req_data.slot_index;
      dec.uniq = req_data.handle_unique;
      unique case (req_data.op)
         OP_CREATE: dec.kind = K_CREATE;
         OP_CHECK:  dec.kind = K_CHECK;
         OP_QUEUE:  dec.kind = K_QUEUE;
         OP_REMOVE: dec.kind = K_REMOVE;
         OP_FLUSH:  dec.kind = K_FLUSH;
         default:   dec.kind = K_NOP;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_take ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule
`default_nettype wire

@@ src/gha_back.sv @@
// ----------------------------------------------------------------------------
// gha_back
// Executes commands against the slot table, free stack and removal queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gha_back import gha_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd_data,
   output logic             cmd_take,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data
);
   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FL_RD, S_FL_EX} state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [SLOTS-1:0]       alive_ff, alive_in;
   logic [SLOTS-1:0]       pending_ff, pending_in;
   logic [CNT_BITS-1:0]    free_depth_ff, free_depth_in;
   logic [CNT_BITS-1:0]    fresh_next_ff, fresh_next_in;
   logic [CNT_BITS-1:0]    queue_depth_ff, queue_depth_in;
   logic [CNT_BITS-1:0]    live_ff, live_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CNT_BITS-1:0]    flushed_ff, flushed_in;
   logic [UNIQUE_BITS-1:0] unique_next_ff, unique_next_in;
   logic [UNIQUE_BITS-1:0] first_uid_ff, first_uid_in;
   logic [UNIQUE_BITS-1:0] limit_ff, limit_in;
   logic [31:0]            created_ff, created_in;
   logic [31:0]            removed_ff, removed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   su_we, fs_we, rq_we;
   logic [SLOT_BITS-1:0]   su_waddr, fs_waddr, fs_wdata, fs_raddr, fs_rdata;
   logic [QIDX_BITS-1:0]   rq_waddr, rq_raddr;
   logic [SLOT_BITS-1:0]   rq_wdata, rq_rdata;
   logic [UNIQUE_BITS-1:0] su_wdata, su_rdata;

   logic                   out_free, finish, kill_en, have, ok;
   logic [SLOT_BITS-1:0]   kill_slot, s;
   logic [2:0]             r_status;
   logic                   r_alive;
   logic [SLOT_BITS-1:0]   r_nslot;
   logic [UNIQUE_BITS-1:0] r_nuniq;

   gha_ram #(.WIDTH(UNIQUE_BITS), .DEPTH(SLOTS)) u_slot_unique (
      .clock, .we(su_we), .waddr(su_waddr), .wdata(su_wdata),
      .raddr(cmd_data.slot), .rdata(su_rdata)
   );
   gha_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_free_stack (
      .clock, .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
      .raddr(fs_raddr), .rdata(fs_rdata)
   );
   gha_ram #(.WIDTH(SLOT_BITS), .DEPTH(QUEUE_DEPTH)) u_removal_queue (
      .clock, .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
      .raddr(rq_raddr), .rdata(rq_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fs_raddr  = SLOT_BITS'(free_depth_ff - 1'b1);
   assign rq_raddr  = idx_ff[QIDX_BITS-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      alive_in       = alive_ff;
      pending_in     = pending_ff;
      free_depth_in  = free_depth_ff;
      fresh_next_in  = fresh_next_ff;
      queue_depth_in = queue_depth_ff;
      live_in        = live_ff;
      idx_in         = idx_ff;
      flushed_in     = flushed_ff;
      unique_next_in = unique_next_ff;
      first_uid_in   = first_uid_ff;
      limit_in       = limit_ff;
      created_in     = created_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      cmd_take       = 1'b0;
      su_we          = 1'b0;
      su_waddr       = cmd_ff.slot;
      su_wdata       = unique_next_ff;
      rq_we          = 1'b0;
      rq_waddr       = queue_depth_ff[QIDX_BITS-1:0];
      rq_wdata       = cmd_ff.slot;
      finish         = 1'b0;
      kill_en        = 1'b0;
      kill_slot      = cmd_ff.slot;
      r_status       = ST_OK;
      r_alive        = 1'b0;
      r_nslot        = '0;
      r_nuniq        = '0;
      have           = (free_depth_ff != '0) || (fresh_next_ff != CNT_BITS'(SLOTS));
      s              = (free_depth_ff != '0) ? fs_rdata : fresh_next_ff[SLOT_BITS-1:0];
      ok             = alive_ff[cmd_ff.slot] && (su_rdata == cmd_ff.uniq);

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take   = 1'b1;
               cmd_in     = cmd_data;
               idx_in     = '0;
               flushed_in = '0;
               state_in   = (cmd_data.kind == K_FLUSH) ? S_FL_RD : S_EXEC;
            end
         end
         S_EXEC: begin
            finish   = 1'b1;
            state_in = S_IDLE;
            unique case (cmd_ff.kind)
               K_CREATE: begin
                  if (!have) begin
                     r_status = ST_TABLE_FULL;
                  end else if (unique_next_ff >= limit_ff) begin
                     r_status = ST_IDS_EXHAUST;
                  end else begin
                     if (free_depth_ff != '0) begin
                        free_depth_in = free_depth_ff - 1'b1;
                     end else begin
                        fresh_next_in = fresh_next_ff + 1'b1;
                     end
                     su_we          = 1'b1;
                     su_waddr       = s;
                     alive_in[s]    = 1'b1;
                     r_nslot        = s;
                     r_nuniq        = unique_next_ff;
                     unique_next_in = unique_next_ff + 1'b1;
                     created_in     = created_ff + 1'b1;
                     live_in        = live_ff + 1'b1;
                  end
               end
               K_CHECK, K_QUEUE, K_REMOVE: begin
                  if ({1'b0, cmd_ff.slot} >= fresh_next_ff) begin
                     r_status = ST_UNALLOCATED;
                  end else begin
                     r_alive = ok;
                     if (!ok) begin
                        r_status = ST_NOT_ALIVE;
                     end else if (cmd_ff.kind == K_QUEUE) begin
                        if (!pending_ff[cmd_ff.slot]) begin
                           if (queue_depth_ff == CNT_BITS'(QUEUE_DEPTH)) begin
                              r_status = ST_QUEUE_FULL;
                           end else begin
                              pending_in[cmd_ff.slot] = 1'b1;
                              rq_we          = 1'b1;
                              queue_depth_in = queue_depth_ff + 1'b1;
                           end
                        end
                     end else if (cmd_ff.kind == K_REMOVE) begin
                        kill_en = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_FL_RD: begin
            if (idx_ff == queue_depth_ff) begin
               finish         = 1'b1;
               queue_depth_in = '0;
               state_in       = S_IDLE;
            end else begin
               state_in = S_FL_EX;
            end
         end
         S_FL_EX: begin
            kill_slot = rq_rdata;
            if (alive_ff[rq_rdata]) begin
               kill_en    = 1'b1;
               flushed_in = flushed_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_FL_RD;
         end
         default: state_in = S_IDLE;
      endcase

      // removal of one live slot: shared by remove-now and flush
      fs_we    = 1'b0;
      fs_waddr = free_depth_ff[SLOT_BITS-1:0];
      fs_wdata = kill_slot;
      if (kill_en) begin
         alive_in[kill_slot]   = 1'b0;
         pending_in[kill_slot] = 1'b0;
         if (free_depth_ff != CNT_BITS'(SLOTS)) begin
            fs_we         = 1'b1;
            free_depth_in = free_depth_ff + 1'b1;
         end
         if (live_ff != '0) begin
            live_in = live_ff - 1'b1;
         end
         removed_in = removed_ff + 1'b1;
      end

      if (finish) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = r_status;
         rsp_in.is_alive      = r_alive;
         rsp_in.new_slot      = r_nslot;
         rsp_in.new_unique    = r_nuniq;
         rsp_in.live_count    = live_in;
         rsp_in.created_total = created_in;
         rsp_in.removed_total = removed_in;
         rsp_in.flushed_count = (cmd_ff.kind == K_FLUSH) ? flushed_ff : '0;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_UID: begin
               first_uid_in   = csr_wdata;
               unique_next_in = csr_wdata;
            end
            CSR_UID_LIMIT: limit_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         alive_ff       <= '0;
         pending_ff     <= '0;
         free_depth_ff  <= '0;
         fresh_next_ff  <= '0;
         queue_depth_ff <= '0;
         live_ff        <= '0;
         flushed_ff     <= '0;
         unique_next_ff <= UNIQUE_BITS'(1);
         first_uid_ff   <= UNIQUE_BITS'(1);
         limit_ff       <= '1;
         created_ff     <= '0;
         removed_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         alive_ff       <= alive_in;
         pending_ff     <= pending_in;
         free_depth_ff  <= free_depth_in;
         fresh_next_ff  <= fresh_next_in;
         queue_depth_ff <= queue_depth_in;
         live_ff        <= live_in;
         flushed_ff     <= flushed_in;
         unique_next_ff <= unique_next_in;
         first_uid_ff   <= first_uid_in;
         limit_ff       <= limit_in;
         created_ff     <= created_in;
         removed_ff     <= removed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

`include "generational_handle_allocator_unit_assert.svh"
   // every allocated slot is either live or sitting on the free stack
   `GHA_ASSERT(a_slot_balance, clock, reset, (10'(live_ff) + 10'(free_depth_ff)) == 10'(fresh_next_ff), "slot accounting broken")
   `GHA_ASSERT(a_busy_no_rsp, clock, reset, (state_ff != S_IDLE) |-> !rsp_valid_ff, "result held while busy")
   `GHA_ASSERT(a_take_starts, clock, reset, cmd_take |=> (state_ff != S_IDLE), "command taken but not run")
   `GHA_NEVER(a_queue_bound, clock, reset, queue_depth_ff > CNT_BITS'(QUEUE_DEPTH), "removal queue overrun")
endmodule
`default_nettype wire

@@ src/generational_handle_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Hands out slot handles with generation ids; deferred and immediate removal.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one op per transfer (create, check, queue removal, remove,
//    flush). req_stall rises when the two-entry command buffer is full.
//  - rsp channel: exactly one result per request, in order. The result sits
//    in an output register until the transfer completes.
//  - csr port: index 0 loads first_unique_id (and the running id), index 1
//    the id limit. Write only while no request is in flight.
//  - Sequence: create/check/queue/remove run in the back end as a slot
//    id RAM read, then an update; a flush does one removal-queue RAM read
//    and one update per queued entry.
//  - One command at a time: the back end finishes each op before taking
//    the next, and starts it only once the output register is free.
//  - Reset: all slots dead, free stack and queue empty, counters zero, ids
//    restart at the first_unique_id reset value. RAM contents need no clear.
//  - While rsp_stall is high the result holds; the front keeps buffering up
//    to two requests before stalling req.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_allocator_unit import gha_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;

   // front: accept and decode, small command queue
   gha_front u_front (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_data, .cmd_take
   );

   // back: slot table, free stack, removal queue and counters
   gha_back u_back (
      .clock, .reset,
      .cmd_valid, .cmd_data, .cmd_take,
      .csr_we, .csr_index, .csr_wdata,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire
